/* src/dnd_pkg.sv */
// Package for the DNS name decompressor: sizes, codes, transaction payload
// types and the back-end state encoding. Depends on nothing.
`default_nettype none

package dnd_pkg;

  localparam int PACKET_BYTES   = 2048;
  localparam int MAX_JUMPS      = 12;
  localparam int MAX_NAME_CHARS = 255;

  localparam int ADDR_W  = $clog2(PACKET_BYTES);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int CUR_W   = 14;
  localparam int JMP_W   = $clog2(MAX_JUMPS + 2);
  localparam int NCH_W   = $clog2(MAX_NAME_CHARS + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] PTR_MASK = 8'hC0;
  localparam logic [7:0] OFS_MASK = 8'h3F;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_JUMPS  = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [10:0] start_pos;
  } req_t;

  typedef struct packed {
    logic [63:0] text_chunk;
    logic [3:0]  chunk_chars;
    logic        last;
    logic [1:0]  status;
    logic [10:0] end_pos;
  } res_t;

  typedef struct packed {
    logic              decode;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        data;
    logic [10:0]       start;
    logic [LEN_W-1:0]  plen;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LEN,
    BK_PTR,
    BK_DOT,
    BK_CADDR,
    BK_CDATA,
    BK_SEND
  } back_state_t;

endpackage

`default_nettype wire

/* src/dnd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module dnd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/dnd_front.sv */
// Front end: accepts request transactions, tracks the load pointer and packet
// length, and turns each request into a command. Depends on dnd_pkg.
`default_nettype none

module dnd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire dnd_pkg::req_t req,
  input  wire logic          full,
  output logic               push,
  output dnd_pkg::cmd_t      cmd
);

  logic [dnd_pkg::ADDR_W-1:0] load_ptr;
  logic [dnd_pkg::LEN_W-1:0]  plen;
  logic                       is_decode;

  assign is_decode = (req.op == dnd_pkg::OP_DECODE);
  assign req_ready = !full;
  assign push      = req_valid && req_ready;

  always_comb begin
    cmd.decode = is_decode;
    cmd.waddr  = load_ptr;
    cmd.data   = req.byte_value;
    cmd.start  = req.start_pos;
    cmd.plen   = plen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr <= '0;
      plen     <= '0;
    end else if (push && !is_decode) begin
      if (req.last_byte) begin
        plen     <= dnd_pkg::LEN_W'(load_ptr) + dnd_pkg::LEN_W'(1);
        load_ptr <= '0;
      end else if (load_ptr == dnd_pkg::ADDR_W'(dnd_pkg::PACKET_BYTES - 1)) begin
        load_ptr <= '0;
      end else begin
        load_ptr <= load_ptr + dnd_pkg::ADDR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/dnd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on dnd_pkg.
`default_nettype none

module dnd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire dnd_pkg::cmd_t push_data,
  output logic               full,
  output logic               valid,
  input  wire logic          pop,
  output dnd_pkg::cmd_t      pop_data
);

  dnd_pkg::cmd_t                entries [dnd_pkg::FIFO_DEPTH];
  logic [dnd_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [dnd_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [dnd_pkg::FIFO_AW:0]    count;
  logic                         do_pop;

  assign full     = (count == (dnd_pkg::FIFO_AW + 1)'(dnd_pkg::FIFO_DEPTH));
  assign valid    = (count != '0);
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + dnd_pkg::FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + dnd_pkg::FIFO_AW'(1);
      end
      if ((push && !full) && !do_pop) begin
        count <= count + (dnd_pkg::FIFO_AW + 1)'(1);
      end else if (!(push && !full) && do_pop) begin
        count <= count - (dnd_pkg::FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/dnd_back.sv */
// Back end: stores packet bytes and walks labels and compression pointers,
// gathering name text into result transactions. Depends on dnd_pkg.
`default_nettype none

module dnd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  input  wire dnd_pkg::cmd_t              cmd,
  output logic                            cmd_pop,
  output logic                            ram_we,
  output logic [dnd_pkg::ADDR_W-1:0]      ram_waddr,
  output logic [7:0]                      ram_wdata,
  output logic [dnd_pkg::ADDR_W-1:0]      ram_raddr,
  input  wire logic [7:0]                 ram_rdata,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output dnd_pkg::res_t                   res
);

  localparam int CMP_W = dnd_pkg::CUR_W + 1;

  dnd_pkg::back_state_t state, state_next, ret_state, ret_state_next;

  logic [dnd_pkg::CUR_W-1:0] cursor, cursor_next;
  logic [dnd_pkg::LEN_W-1:0] endp, endp_next;
  logic                      taken, taken_next;
  logic [dnd_pkg::JMP_W-1:0] jumps, jumps_next;
  logic                      labels_any, labels_any_next;
  logic [63:0]               acc, acc_next;
  logic [2:0]                count, count_next;
  logic [dnd_pkg::NCH_W-1:0] nchars, nchars_next;
  logic [dnd_pkg::LEN_W-1:0] pos, pos_next;
  logic [7:0]                rem, rem_next;
  logic [5:0]                hi, hi_next;
  logic [dnd_pkg::LEN_W-1:0] plen, plen_next;
  dnd_pkg::res_t             pend, pend_next;
  dnd_pkg::res_t             out_reg, out_next;
  logic                      out_valid, out_valid_next;

  logic                      start_out, is_zero, is_ptr, ptr_trunc, label_over;
  logic                      jump_over, target_out, label_end_out, too_long, chunk_full;
  logic                      slot_free;
  logic [dnd_pkg::CUR_W-1:0] target;
  logic [7:0]                ch;
  logic [63:0]               acc_new;
  logic [CMP_W-1:0]          cur_ext, plen_ext;

  function automatic dnd_pkg::res_t fail_res(dnd_pkg::status_t st);
    dnd_pkg::res_t r;
    r             = '0;
    r.last        = 1'b1;
    r.status      = st;
    return r;
  endfunction

  assign cur_ext       = CMP_W'(cursor);
  assign plen_ext      = CMP_W'(plen);
  assign start_out     = CMP_W'(cmd.start) >= CMP_W'(cmd.plen);
  assign is_zero       = (ram_rdata == 8'h00);
  assign is_ptr        = ((ram_rdata & dnd_pkg::PTR_MASK) == dnd_pkg::PTR_MASK);
  assign ptr_trunc     = (cur_ext + CMP_W'(1)) >= plen_ext;
  assign label_over    = (cur_ext + CMP_W'(1) + CMP_W'(ram_rdata)) > plen_ext;
  assign target        = {hi, ram_rdata};
  assign jump_over     = (jumps == dnd_pkg::JMP_W'(dnd_pkg::MAX_JUMPS));
  assign target_out    = CMP_W'(target) >= plen_ext;
  assign label_end_out = pos >= plen;
  assign too_long      = nchars >= dnd_pkg::NCH_W'(dnd_pkg::MAX_NAME_CHARS);
  assign chunk_full    = (count == 3'd7);
  assign ch            = (state == dnd_pkg::BK_DOT) ? dnd_pkg::DOT_CHAR : ram_rdata;
  assign acc_new       = acc | (64'(ch) << {count, 3'b000});
  assign slot_free     = !out_valid || res_ready;

  assign res_valid = out_valid;
  assign res       = out_reg;

  always_comb begin
    state_next = state;
    case (state)
      dnd_pkg::BK_IDLE: begin
        if (cmd_valid && cmd.decode) begin
          state_next = start_out ? dnd_pkg::BK_SEND : dnd_pkg::BK_FETCH;
        end
      end
      dnd_pkg::BK_FETCH: state_next = dnd_pkg::BK_LEN;
      dnd_pkg::BK_LEN: begin
        if (is_zero) begin
          state_next = dnd_pkg::BK_SEND;
        end else if (is_ptr) begin
          state_next = ptr_trunc ? dnd_pkg::BK_SEND : dnd_pkg::BK_PTR;
        end else if (label_over) begin
          state_next = dnd_pkg::BK_SEND;
        end else begin
          state_next = labels_any ? dnd_pkg::BK_DOT : dnd_pkg::BK_CADDR;
        end
      end
      dnd_pkg::BK_PTR: begin
        state_next = (jump_over || target_out) ? dnd_pkg::BK_SEND : dnd_pkg::BK_FETCH;
      end
      dnd_pkg::BK_DOT, dnd_pkg::BK_CDATA: begin
        state_next = (too_long || chunk_full) ? dnd_pkg::BK_SEND : dnd_pkg::BK_CADDR;
      end
      dnd_pkg::BK_CADDR: begin
        if (rem == 8'd0) begin
          state_next = label_end_out ? dnd_pkg::BK_SEND : dnd_pkg::BK_FETCH;
        end else begin
          state_next = dnd_pkg::BK_CDATA;
        end
      end
      dnd_pkg::BK_SEND: begin
        if (slot_free) begin
          state_next = ret_state;
        end
      end
      default: state_next = dnd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ret_state_next  = ret_state;
    cursor_next     = cursor;
    endp_next       = endp;
    taken_next      = taken;
    jumps_next      = jumps;
    labels_any_next = labels_any;
    acc_next        = acc;
    count_next      = count;
    nchars_next     = nchars;
    pos_next        = pos;
    rem_next        = rem;
    hi_next         = hi;
    plen_next       = plen;
    pend_next       = pend;
    out_next        = out_reg;
    out_valid_next  = out_valid && !res_ready;
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cmd.waddr;
    ram_wdata       = cmd.data;
    ram_raddr       = cursor[dnd_pkg::ADDR_W-1:0];
    case (state)
      dnd_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          if (!cmd.decode) begin
            ram_we = 1'b1;
          end else begin
            plen_next       = cmd.plen;
            cursor_next     = dnd_pkg::CUR_W'(cmd.start);
            endp_next       = dnd_pkg::LEN_W'(cmd.start);
            taken_next      = 1'b0;
            jumps_next      = '0;
            labels_any_next = 1'b0;
            acc_next        = '0;
            count_next      = '0;
            nchars_next     = '0;
            pend_next       = fail_res(dnd_pkg::ST_BOUNDS);
            ret_state_next  = dnd_pkg::BK_IDLE;
          end
        end
      end
      dnd_pkg::BK_FETCH: begin
        ram_raddr = cursor[dnd_pkg::ADDR_W-1:0];
      end
      dnd_pkg::BK_LEN: begin
        ret_state_next = dnd_pkg::BK_IDLE;
        if (is_zero) begin
          pend_next.text_chunk  = acc;
          pend_next.chunk_chars = {1'b0, count};
          pend_next.last        = 1'b1;
          pend_next.status      = dnd_pkg::ST_OK;
          pend_next.end_pos     = taken ? endp[10:0] : 11'(cursor + dnd_pkg::CUR_W'(1));
        end else if (is_ptr) begin
          pend_next = fail_res(dnd_pkg::ST_BOUNDS);
          hi_next   = ram_rdata[5:0] & dnd_pkg::OFS_MASK[5:0];
          ram_raddr = dnd_pkg::ADDR_W'(cursor + dnd_pkg::CUR_W'(1));
        end else begin
          pend_next       = fail_res(dnd_pkg::ST_BOUNDS);
          rem_next        = ram_rdata;
          pos_next        = dnd_pkg::LEN_W'(cursor + dnd_pkg::CUR_W'(1));
          labels_any_next = label_over ? labels_any : 1'b1;
        end
      end
      dnd_pkg::BK_PTR: begin
        ret_state_next = dnd_pkg::BK_IDLE;
        if (!taken) begin
          endp_next  = dnd_pkg::LEN_W'(cursor + dnd_pkg::CUR_W'(2));
          taken_next = 1'b1;
        end
        jumps_next  = jumps + dnd_pkg::JMP_W'(1);
        cursor_next = target;
        pend_next   = jump_over ? fail_res(dnd_pkg::ST_JUMPS) : fail_res(dnd_pkg::ST_BOUNDS);
      end
      dnd_pkg::BK_DOT, dnd_pkg::BK_CDATA: begin
        if (too_long) begin
          pend_next      = fail_res(dnd_pkg::ST_LONG);
          ret_state_next = dnd_pkg::BK_IDLE;
        end else begin
          nchars_next = nchars + dnd_pkg::NCH_W'(1);
          if (state == dnd_pkg::BK_CDATA) begin
            pos_next = pos + dnd_pkg::LEN_W'(1);
            rem_next = rem - 8'd1;
          end
          if (chunk_full) begin
            pend_next             = '0;
            pend_next.text_chunk  = acc_new;
            pend_next.chunk_chars = 4'd8;
            pend_next.status      = dnd_pkg::ST_OK;
            acc_next              = '0;
            count_next            = '0;
            ret_state_next        = dnd_pkg::BK_CADDR;
          end else begin
            acc_next   = acc_new;
            count_next = count + 3'd1;
          end
        end
      end
      dnd_pkg::BK_CADDR: begin
        ram_raddr = pos[dnd_pkg::ADDR_W-1:0];
        if (rem == 8'd0) begin
          cursor_next    = dnd_pkg::CUR_W'(pos);
          endp_next      = taken ? endp : pos;
          pend_next      = fail_res(dnd_pkg::ST_BOUNDS);
          ret_state_next = dnd_pkg::BK_IDLE;
        end
      end
      dnd_pkg::BK_SEND: begin
        if (slot_free) begin
          out_next       = pend;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        ret_state_next = dnd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dnd_pkg::BK_IDLE;
      ret_state <= dnd_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cursor     <= cursor_next;
    endp       <= endp_next;
    taken      <= taken_next;
    jumps      <= jumps_next;
    labels_any <= labels_any_next;
    acc        <= acc_next;
    count      <= count_next;
    nchars     <= nchars_next;
    pos        <= pos_next;
    rem        <= rem_next;
    hi         <= hi_next;
    plen       <= plen_next;
    pend       <= pend_next;
    out_reg    <= out_next;
  end

endmodule

`default_nettype wire

/* src/dns_name_decompressor_top.sv */
// Top level of the DNS name decompressor: front end, command queue, back end
// and packet RAM. Depends on dnd_pkg, dnd_ram, dnd_front, dnd_fifo, dnd_back.
//
// Usage. Request transactions arrive on req with valid and ready. A load
// request stores one packet byte; the byte flagged last_byte ends the packet
// and fixes its length. A decode request walks the name at start_pos and
// returns one or more result transactions on res, eight characters each but
// the last, which holds fewer, is flagged last and carries the status and
// end offset. Loads are taken at one per cycle while the queue has room and
// give no result. A decode reads every length byte, compression pointer and
// label character through the single registered read port of the packet
// RAM. When the start offset lies past the end of the packet, the decode
// goes from idle straight to the send state and the result register;
// otherwise it first passes the fetch and length states. A four-entry
// queue lets requests, including further loads, be accepted while a decode
// is still running. When the receiver stalls, the result register holds
// and the walk waits; the queue then fills and req_ready falls. Reset
// clears the packet length, the load position, the queue and the result
// valid flag; the packet store is undefined until written.
`default_nettype none

module dns_name_decompressor_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire dnd_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_ready,
  output dnd_pkg::res_t      res
);

  logic                       full;
  logic                       push;
  dnd_pkg::cmd_t              push_cmd;
  logic                       cmd_valid;
  logic                       cmd_pop;
  dnd_pkg::cmd_t              cmd;
  logic                       ram_we;
  logic [dnd_pkg::ADDR_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic [dnd_pkg::ADDR_W-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  dnd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .full      (full),
    .push      (push),
    .cmd       (push_cmd)
  );

  dnd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .valid     (cmd_valid),
    .pop       (cmd_pop),
    .pop_data  (cmd)
  );

  dnd_ram #(
    .WIDTH (8),
    .DEPTH (dnd_pkg::PACKET_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dnd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result transaction presented straight after reset");

  a_chunk_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |->
      (res.chunk_chars == 4'd8 && res.status == dnd_pkg::ST_OK && res.end_pos == 11'd0))
    else $error("intermediate chunk is not a full, clean chunk");

  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last && res.status != dnd_pkg::ST_OK) |->
      (res.chunk_chars == 4'd0 && res.text_chunk == 64'd0 && res.end_pos == 11'd0))
    else $error("failed decode carries text or an end offset");

  a_final_short: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |-> (res.chunk_chars < 4'd8))
    else $error("final result holds a full chunk");

endmodule

`default_nettype wire
